FILE: src/percent_decode_utf8_check_assert.svh
`ifndef PERCENT_DECODE_UTF8_CHECK_ASSERT_SVH
`define PERCENT_DECODE_UTF8_CHECK_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PDU8_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PDU8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pdu8_pkg.sv
package pdu8_pkg;

    typedef enum logic [2:0] {
        VERD_OK    = 3'd0,
        VERD_CTRL  = 3'd1,
        VERD_HEX   = 3'd2,
        VERD_TRUNC = 3'd3,
        VERD_UTF8  = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_ONE  = 2'd1,
        ESC_TWO  = 2'd2
    } esc_phase_t;

    typedef enum logic [2:0] {
        LEAD_PLAIN = 3'd0,
        LEAD_E0    = 3'd1,
        LEAD_ED    = 3'd2,
        LEAD_F0    = 3'd3,
        LEAD_F4    = 3'd4
    } lead_class_t;

    typedef struct packed {
        logic     kind;
        logic [7:0] data;
        verdict_t verd;
        logic     last;
    } item_t;

    localparam int unsigned MAX_ITEMS = 4;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [7:0] U8_TWO_LO   = 8'hC2;
    localparam logic [7:0] U8_TWO_HI   = 8'hDF;
    localparam logic [7:0] U8_THREE_LO = 8'hE0;
    localparam logic [7:0] U8_THREE_HI = 8'hEF;
    localparam logic [7:0] U8_LEAD_ED  = 8'hED;
    localparam logic [7:0] U8_FOUR_LO  = 8'hF0;
    localparam logic [7:0] U8_FOUR_HI  = 8'hF4;
    localparam logic [7:0] U8_CONT_LO  = 8'h80;
    localparam logic [7:0] U8_CONT_HI  = 8'hBF;
    localparam logic [7:0] U8_E0_LO    = 8'hA0;
    localparam logic [7:0] U8_ED_HI    = 8'h9F;
    localparam logic [7:0] U8_F0_LO    = 8'h90;
    localparam logic [7:0] U8_F4_HI    = 8'h8F;

    // {valid, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, ch[3:0]};
        end
        else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
            r = {1'b1, ch[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

FILE: src/percent_decode_utf8_check.sv
// percent_decode_utf8_check: percent-decoder for one URI component, with
// strict UTF-8 checking of the decoded bytes.
//
// Input stream s_axis: one raw byte per transaction, tlast on the last byte
// of the component. Output stream m_axis: decoded data bytes (tuser 0) and,
// after the last input byte, one verdict item (tuser 1); tlast marks the last
// result caused by each input byte. cfg_we/cfg_wdata set query mode; the user
// must write it only while the block is idle, which the block does not enforce.
//
// A byte taken is held in the input register, decoded out of it and its
// results loaded into the result register that drives m_axis. Throughput is
// one byte per cycle while m_axis_tready stays high; a byte giving several
// results (path-mode escaped slash echoed as three characters, or data plus
// verdict) holds the result register until all of them are taken.
//
// Reset clears all component state and query mode. When the receiver
// deasserts m_axis_tready the current result holds, the input register fills
// and s_axis_tready drops once it holds a byte; nothing is lost.
`include "percent_decode_utf8_check_assert.svh"

module percent_decode_utf8_check
    import pdu8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // query_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // is_final
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [10:8] verdict, rest zero
    output logic        m_axis_tuser,   // item_kind
    output logic        m_axis_tlast    // end_of_run
);

    logic        query_mode_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_final_reg;

    esc_phase_t  esc_reg,     esc_next;
    logic [7:0]  saved_reg,   saved_next;
    logic [1:0]  pend_reg,    pend_next;
    lead_class_t cls_reg,     cls_next;
    verdict_t    derr_reg,    derr_next;
    logic        uerr_reg,    uerr_next;

    item_t       itm_reg [MAX_ITEMS];
    item_t       itm_next [MAX_ITEMS];
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;

    logic        take;
    logic        load_ok;
    logic        fire;

    logic [4:0]  hi_nib;
    logic [4:0]  lo_nib;
    logic [7:0]  dec_val;
    logic        emit;
    logic        echo;
    logic [7:0]  ebyte;
    logic [7:0]  c_lo;
    logic [7:0]  c_hi;
    logic [1:0]  n_data;
    logic [2:0]  n_new;
    verdict_t    verd;
    logic [1:0]  pend_f;
    lead_class_t cls_f;
    logic        uerr_f;
    verdict_t    derr_f;
    esc_phase_t  esc_f;

    logic        out_verd;
    logic        out_data;
    logic        err_fire;
    logic        fin_fire;
    logic        comp_idle;

    assign take          = m_axis_tvalid && m_axis_tready;
    assign load_ok       = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_axis_tready);
    assign fire          = in_valid_reg && load_ok;
    assign s_axis_tready = !in_valid_reg || load_ok;

    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tdata  = {5'd0, itm_reg[0].verd, itm_reg[0].data};
    assign m_axis_tuser  = itm_reg[0].kind;
    assign m_axis_tlast  = itm_reg[0].last;

    assign hi_nib  = hex_nibble(saved_reg);
    assign lo_nib  = hex_nibble(in_byte_reg);
    assign dec_val = {hi_nib[3:0], lo_nib[3:0]};

    // escape decoding
    always_comb
    begin
        esc_f      = esc_reg;
        saved_next = saved_reg;
        derr_f     = derr_reg;
        emit       = 1'b0;
        echo       = 1'b0;
        ebyte      = in_byte_reg;
        if (derr_reg == VERD_OK)
        begin
            unique case (esc_reg)
                ESC_ONE:
                begin
                    saved_next = in_byte_reg;
                    esc_f      = ESC_TWO;
                    if (in_final_reg)
                    begin
                        derr_f = VERD_TRUNC;
                    end
                end
                ESC_TWO:
                begin
                    esc_f = ESC_IDLE;
                    priority if (!hi_nib[4] || !lo_nib[4] || dec_val < CTRL_LIMIT)
                    begin
                        derr_f = VERD_HEX;
                    end
                    else if (dec_val == CH_SLASH && !query_mode_reg)
                    begin
                        echo  = 1'b1;
                        ebyte = CH_PERCENT;
                    end
                    else
                    begin
                        emit  = 1'b1;
                        ebyte = dec_val;
                    end
                end
                default:
                begin
                    esc_f = ESC_IDLE;
                    priority if (in_byte_reg == CH_PERCENT)
                    begin
                        esc_f = ESC_ONE;
                        if (in_final_reg)
                        begin
                            derr_f = VERD_TRUNC;
                        end
                    end
                    else if (in_byte_reg < CTRL_LIMIT)
                    begin
                        derr_f = VERD_CTRL;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            endcase
        end
    end

    // UTF-8 check; echoed characters are all ASCII, so feeding the first is enough
    always_comb
    begin
        unique case (cls_reg)
            LEAD_E0:
            begin
                c_lo = U8_E0_LO;
                c_hi = U8_CONT_HI;
            end
            LEAD_ED:
            begin
                c_lo = U8_CONT_LO;
                c_hi = U8_ED_HI;
            end
            LEAD_F0:
            begin
                c_lo = U8_F0_LO;
                c_hi = U8_CONT_HI;
            end
            LEAD_F4:
            begin
                c_lo = U8_CONT_LO;
                c_hi = U8_F4_HI;
            end
            default:
            begin
                c_lo = U8_CONT_LO;
                c_hi = U8_CONT_HI;
            end
        endcase
    end

    always_comb
    begin
        pend_f = pend_reg;
        cls_f  = cls_reg;
        uerr_f = uerr_reg;
        if ((emit || echo) && !uerr_reg)
        begin
            if (pend_reg == 2'd0)
            begin
                cls_f = LEAD_PLAIN;
                priority if (!ebyte[7])
                begin
                    pend_f = 2'd0;
                end
                else if (ebyte >= U8_TWO_LO && ebyte <= U8_TWO_HI)
                begin
                    pend_f = 2'd1;
                end
                else if (ebyte >= U8_THREE_LO && ebyte <= U8_THREE_HI)
                begin
                    pend_f = 2'd2;
                    if (ebyte == U8_THREE_LO)
                    begin
                        cls_f = LEAD_E0;
                    end
                    else if (ebyte == U8_LEAD_ED)
                    begin
                        cls_f = LEAD_ED;
                    end
                end
                else if (ebyte >= U8_FOUR_LO && ebyte <= U8_FOUR_HI)
                begin
                    pend_f = 2'd3;
                    if (ebyte == U8_FOUR_LO)
                    begin
                        cls_f = LEAD_F0;
                    end
                    else if (ebyte == U8_FOUR_HI)
                    begin
                        cls_f = LEAD_F4;
                    end
                end
                else
                begin
                    uerr_f = 1'b1;
                end
            end
            else
            begin
                cls_f = LEAD_PLAIN;
                if (ebyte < c_lo || ebyte > c_hi)
                begin
                    uerr_f = 1'b1;
                    pend_f = 2'd0;
                end
                else
                begin
                    pend_f = pend_reg - 2'd1;
                end
            end
        end
    end

    // verdict, end-of-component clear, result group
    always_comb
    begin
        verd = derr_f;
        if (derr_f == VERD_OK && (uerr_f || pend_f != 2'd0))
        begin
            verd = VERD_UTF8;
        end

        esc_next  = esc_f;
        pend_next = pend_f;
        cls_next  = cls_f;
        derr_next = derr_f;
        uerr_next = uerr_f;
        if (in_final_reg)
        begin
            esc_next  = ESC_IDLE;
            pend_next = 2'd0;
            cls_next  = LEAD_PLAIN;
            derr_next = VERD_OK;
            uerr_next = 1'b0;
        end

        n_data = echo ? 2'd3 : (emit ? 2'd1 : 2'd0);
        n_new  = {1'b0, n_data} + {2'd0, in_final_reg};

        for (int k = 0; k < MAX_ITEMS; k++)
        begin
            itm_next[k] = '{kind: 1'b0, data: 8'd0, verd: VERD_OK, last: 1'b0};
        end
        if (echo)
        begin
            itm_next[0].data = CH_PERCENT;
            itm_next[1].data = saved_reg;
            itm_next[2].data = in_byte_reg;
        end
        else if (emit)
        begin
            itm_next[0].data = ebyte;
        end
        if (in_final_reg)
        begin
            itm_next[n_data].kind = 1'b1;
            itm_next[n_data].verd = verd;
        end
        for (int k = 0; k < MAX_ITEMS; k++)
        begin
            itm_next[k].last = ((3'(k) + 3'd1) == n_new);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (fire)
        begin
            cnt_next = n_new;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_mode_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            in_byte_reg    <= 8'd0;
            in_final_reg   <= 1'b0;
            esc_reg        <= ESC_IDLE;
            saved_reg      <= 8'd0;
            pend_reg       <= 2'd0;
            cls_reg        <= LEAD_PLAIN;
            derr_reg       <= VERD_OK;
            uerr_reg       <= 1'b0;
            cnt_reg        <= 3'd0;
            for (int k = 0; k < MAX_ITEMS; k++)
            begin
                itm_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                query_mode_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (s_axis_tready && s_axis_tvalid)
            begin
                in_byte_reg  <= s_axis_tdata;
                in_final_reg <= s_axis_tlast;
            end
            if (fire)
            begin
                esc_reg   <= esc_next;
                saved_reg <= saved_next;
                pend_reg  <= pend_next;
                cls_reg   <= cls_next;
                derr_reg  <= derr_next;
                uerr_reg  <= uerr_next;
                for (int k = 0; k < MAX_ITEMS; k++)
                begin
                    itm_reg[k] <= itm_next[k];
                end
            end
            else if (take)
            begin
                for (int k = 0; k < MAX_ITEMS - 1; k++)
                begin
                    itm_reg[k] <= itm_reg[k + 1];
                end
            end
            cnt_reg <= cnt_next;
        end
    end

    assign out_verd  = m_axis_tvalid && m_axis_tuser;
    assign out_data  = m_axis_tvalid && !m_axis_tuser;
    assign err_fire  = fire && derr_reg != VERD_OK;
    assign fin_fire  = fire && in_final_reg;
    assign comp_idle = esc_reg == ESC_IDLE && pend_reg == 2'd0 && derr_reg == VERD_OK
                       && !uerr_reg;

    `PDU8_ASSERT_NOW(a_verdict_ends_run, out_verd, m_axis_tlast, "verdict not last of run")
    `PDU8_ASSERT_NOW(a_data_no_verdict, out_data, m_axis_tdata[10:8] == 3'd0, "data with verdict")
    `PDU8_ASSERT_NOW(a_error_blocks_data, err_fire, !emit && !echo, "data after decode error")
    `PDU8_ASSERT_NEXT(a_final_clears, fin_fire, comp_idle, "state not cleared after last byte")

endmodule

FILE: dv/tb_percent_decode_utf8_check.sv
`timescale 1ns / 100ps

module tb_percent_decode_utf8_check
    import pdu8_pkg::*;
();

    typedef struct packed {
        logic [7:0] in_byte;
        logic       fin;
        logic       typed;
        logic [7:0] typed_val;  // data byte, or verdict on a final row
        logic       to_query;   // switch to query mode before this row
    } row_t;

    localparam int DIR_ROWS = 27;

    localparam row_t DIRECTED [DIR_ROWS] = '{
        '{8'h20, 1'b0, 1'b1, 8'h20, 1'b0},
        '{8'h25, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h34, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h31, 1'b0, 1'b1, 8'h41, 1'b0},
        '{8'h25, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h32, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h66, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h7E, 1'b1, 1'b1, {5'd0, VERD_OK}, 1'b0},
        '{8'h00, 1'b1, 1'b1, {5'd0, VERD_CTRL}, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h25, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h30, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h30, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h78, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h79, 1'b1, 1'b1, {5'd0, VERD_HEX}, 1'b0},
        '{8'h25, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h47, 1'b1, 1'b1, {5'd0, VERD_TRUNC}, 1'b0},
        '{8'h25, 1'b1, 1'b1, {5'd0, VERD_TRUNC}, 1'b0},
        '{8'hE0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h80, 1'b1, 1'b1, {5'd0, VERD_UTF8}, 1'b0},
        '{8'h25, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h61, 1'b1, 1'b1, {5'd0, VERD_HEX}, 1'b0},
        '{8'hF4, 1'b1, 1'b1, {5'd0, VERD_UTF8}, 1'b0},
        '{8'h25, 1'b0, 1'b0, 8'h00, 1'b1},
        '{8'h32, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h46, 1'b1, 1'b1, {5'd0, VERD_OK}, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast = 1'b0;    // is_final
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] data_byte, [10:8] verdict
    logic        m_axis_tuser;           // item_kind
    logic        m_axis_tlast;           // end_of_run

    // decoder state as seen from outside
    logic        query_mode_q = 1'b0;
    esc_phase_t  esc_phase = ESC_IDLE;
    logic [7:0]  hex_first = 8'h00;
    logic [1:0]  u8_left = 2'd0;
    lead_class_t u8_lead = LEAD_PLAIN;
    verdict_t    dec_err = VERD_OK;
    logic        u8_bad = 1'b0;

    item_t       output_due [$];
    logic [7:0]  comp_bytes [$];
    int          mismatches = 0;
    int          tx_gap_pct = 25;
    int          rx_stall_pct = 25;
    bit          hold_req = 1'b0;

    percent_decode_utf8_check u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic void due_add(input item_t it);
        output_due.insert(output_due.size(), it);
    endfunction

    function automatic void comp_add(input logic [7:0] b);
        comp_bytes.insert(comp_bytes.size(), b);
    endfunction

    function automatic int hex_value(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39)
            return int'(ch) - 'h30;
        if (ch >= 8'h41 && ch <= 8'h46)
            return int'(ch) - 'h41 + 10;
        if (ch >= 8'h61 && ch <= 8'h66)
            return int'(ch) - 'h61 + 10;
        return -1;
    endfunction

    function automatic void clear_component();
        esc_phase = ESC_IDLE;
        hex_first = 8'h00;
        u8_left   = 2'd0;
        u8_lead   = LEAD_PLAIN;
        dec_err   = VERD_OK;
        u8_bad    = 1'b0;
    endfunction

    function automatic void track_utf8(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        if (u8_bad)
            return;
        if (u8_left == 2'd0)
        begin
            u8_lead = LEAD_PLAIN;
            if (b <= 8'h7F)
                return;
            if (b >= U8_TWO_LO && b <= U8_TWO_HI)
                u8_left = 2'd1;
            else if (b >= U8_THREE_LO && b <= U8_THREE_HI)
            begin
                u8_left = 2'd2;
                if (b == U8_THREE_LO)
                    u8_lead = LEAD_E0;
                else if (b == U8_LEAD_ED)
                    u8_lead = LEAD_ED;
            end
            else if (b >= U8_FOUR_LO && b <= U8_FOUR_HI)
            begin
                u8_left = 2'd3;
                if (b == U8_FOUR_LO)
                    u8_lead = LEAD_F0;
                else if (b == U8_FOUR_HI)
                    u8_lead = LEAD_F4;
            end
            else
                u8_bad = 1'b1;
            return;
        end
        lo = U8_CONT_LO;
        hi = U8_CONT_HI;
        case (u8_lead)
            LEAD_E0: lo = U8_E0_LO;
            LEAD_ED: hi = U8_ED_HI;
            LEAD_F0: lo = U8_F0_LO;
            LEAD_F4: hi = U8_F4_HI;
            default: ;
        endcase
        if (b < lo || b > hi)
        begin
            u8_bad  = 1'b1;
            u8_left = 2'd0;
        end
        else
            u8_left = u8_left - 2'd1;
        u8_lead = LEAD_PLAIN;
    endfunction

    function automatic void emit_decoded(input logic [7:0] b);
        due_add('{1'b0, b, VERD_OK, 1'b0});
        track_utf8(b);
    endfunction

    // queues the results one accepted input byte gives rise to
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        int         hi;
        int         lo;
        int         n0;
        logic [7:0] v;
        verdict_t   verd;
        n0 = output_due.size();
        if (dec_err == VERD_OK)
        begin
            case (esc_phase)
                ESC_ONE:
                begin
                    hex_first = b;
                    esc_phase = ESC_TWO;
                    if (fin)
                        dec_err = VERD_TRUNC;
                end
                ESC_TWO:
                begin
                    hi = hex_value(hex_first);
                    lo = hex_value(b);
                    esc_phase = ESC_IDLE;
                    if (hi < 0 || lo < 0)
                        dec_err = VERD_HEX;
                    else
                    begin
                        v = 8'(hi * 16 + lo);
                        if (v < CTRL_LIMIT)
                            dec_err = VERD_HEX;
                        else if (v == CH_SLASH && !query_mode_q)
                        begin
                            emit_decoded(CH_PERCENT);
                            emit_decoded(hex_first);
                            emit_decoded(b);
                        end
                        else
                            emit_decoded(v);
                    end
                end
                default:
                begin
                    esc_phase = ESC_IDLE;
                    if (b == CH_PERCENT)
                    begin
                        esc_phase = ESC_ONE;
                        if (fin)
                            dec_err = VERD_TRUNC;
                    end
                    else if (b < CTRL_LIMIT)
                        dec_err = VERD_CTRL;
                    else
                        emit_decoded(b);
                end
            endcase
        end
        if (fin)
        begin
            verd = dec_err;
            if (verd == VERD_OK && (u8_bad || u8_left != 2'd0))
                verd = VERD_UTF8;
            due_add('{1'b1, 8'h00, verd, 1'b0});
            clear_component();
        end
        if (output_due.size() > n0)
            output_due[output_due.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic void add_escape(input logic [7:0] v);
        comp_add(CH_PERCENT);
        comp_add(hex_char(v[7:4]));
        comp_add(hex_char(v[3:0]));
    endfunction

    // one multi-byte sequence, bytes raw or escaped, now and then broken
    function automatic void add_utf8();
        logic [31:0] cp;
        logic [7:0]  seq [4];
        int          len;
        int          sel;
        len = $urandom_range(2, 4);
        sel = $urandom_range(0, 3);
        case (len)
            2:
            begin
                cp = $urandom_range('h80, 'h7FF);
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                if (sel == 0)
                    cp = $urandom_range('h800, 'hFFF);
                else if (sel == 1)
                    cp = $urandom_range('hD000, 'hD7FF);
                else
                begin
                    do
                        cp = $urandom_range('h800, 'hFFFF);
                    while (cp >= 'hD800 && cp <= 'hDFFF);
                end
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                if (sel == 0)
                    cp = $urandom_range('h10000, 'h3FFFF);
                else if (sel == 1)
                    cp = $urandom_range('h100000, 'h10FFFF);
                else
                    cp = $urandom_range('h10000, 'h10FFFF);
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 15)
            len--;
        else if (sel < 30)
            seq[$urandom_range(1, len - 1)] = 8'($urandom_range('h20, 'hFF));
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 1))
                comp_add(seq[k]);
            else
                add_escape(seq[k]);
        end
    endfunction

    function automatic void build_component();
        int         tokens;
        int         r;
        logic [7:0] v;
        comp_bytes.delete();
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                v = 8'($urandom_range('h20, 'h7E));
                comp_add(v == CH_PERCENT ? 8'h41 : v);
            end
            else if (r < 55)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    v = CH_SLASH;
                else if (r < 20)
                    v = 8'($urandom_range(0, 'h1F));
                else
                    v = 8'($urandom_range('h20, 'hFF));
                add_escape(v);
            end
            else if (r < 75)
                add_utf8();
            else if (r < 85)
                comp_add(8'($urandom_range(0, 255)));
            else if (r < 92)
            begin
                comp_add(CH_PERCENT);
                comp_add(8'($urandom_range(0, 255)));
                comp_add(8'($urandom_range(0, 255)));
            end
            else
                comp_add(8'($urandom_range('h80, 'hFF)));
        end
        // escape cut short by the end of the component
        r = $urandom_range(0, 99);
        if (r < 5)
            comp_add(CH_PERCENT);
        else if (r < 10)
        begin
            comp_add(CH_PERCENT);
            comp_add(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin,
                             input logic typed, input logic [7:0] typed_val);
        int gap;
        gap = 0;
        if ($urandom_range(1, 100) <= tx_gap_pct)
            gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_byte(b, fin);
        if (typed)
        begin
            if (fin)
                output_due[output_due.size() - 1].verd = verdict_t'(typed_val[2:0]);
            else
                output_due[output_due.size() - 1].data = typed_val;
        end
    endtask

    // only once every due result has arrived
    task automatic set_query_mode(input logic mode);
        s_axis_tvalid <= 1'b0;
        while (output_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        query_mode_q = mode;
    endtask

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        item_t want;
        if (output_due.size() == 0)
        begin
            $error("result with nothing due: tuser %0h tdata %0h", m_axis_tuser, m_axis_tdata);
            mismatches++;
            return;
        end
        want = output_due.pop_front();
        compare_field("item_kind", {7'd0, want.kind}, {7'd0, m_axis_tuser});
        compare_field("data_byte", want.data, m_axis_tdata[7:0]);
        compare_field("verdict", {5'd0, want.verd}, {5'd0, m_axis_tdata[10:8]});
        compare_field("end_of_run", {7'd0, want.last}, {7'd0, m_axis_tlast});
        compare_field("tdata padding", 8'h00, {3'd0, m_axis_tdata[15:11]});
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int  stall;
        int  hold;
        bit  hold_done;
        stall     = 0;
        hold      = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_result();
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold      = 120;
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(1, 100) <= rx_stall_pct)
            begin
                stall = gap_len() - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED[i].to_query)
                set_query_mode(1'b1);
            send_byte(DIRECTED[i].in_byte, DIRECTED[i].fin,
                      DIRECTED[i].typed, DIRECTED[i].typed_val);
        end
        for (int ph = 0; ph < 4; ph++)
        begin
            set_query_mode(ph[0]);
            case (ph)
                0:
                begin
                    tx_gap_pct   = 25;
                    rx_stall_pct = 25;
                end
                1:
                begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_gap_pct   = 50;
                    rx_stall_pct = 50;
                end
                default:
                begin
                    tx_gap_pct   = 15;
                    rx_stall_pct = 15;
                end
            endcase
            n = 0;
            while (n < 100)
            begin
                if (ph == 3 && n >= 40)
                    hold_req = 1'b1;
                build_component();
                foreach (comp_bytes[k])
                    send_byte(comp_bytes[k], k == comp_bytes.size() - 1, 1'b0, 8'h00);
                n += comp_bytes.size();
            end
        end
        s_axis_tvalid <= 1'b0;
        while (output_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/pdu8_pkg.sv
src/percent_decode_utf8_check.sv
dv/tb_percent_decode_utf8_check.sv
